// File: sv/bdq_pkg.sv
// Shared widths, command codes and status codes for the bounded deque unit.
`timescale 1ns / 1ps

package bdq_pkg;

    // Field widths of the command and result beats.
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP_FWD   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DUMP_REV   = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// File: sv/bdq_in_if.sv
// Command channel of the bounded deque unit: valid, ready and the command beat.
`timescale 1ns / 1ps

interface bdq_in_if;

    logic                            valid;
    logic                            ready;
    logic [bdq_pkg::CMD_W-1:0]       cmd;
    logic signed [bdq_pkg::DATA_W-1:0] push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);

endinterface

// File: sv/bdq_out_if.sv
// Result channel of the bounded deque unit: valid, ready and the result beat.
`timescale 1ns / 1ps

interface bdq_out_if #(
    parameter int CNT_W = 5
);

    logic                              valid;
    logic                              ready;
    logic [bdq_pkg::STATUS_W-1:0]      status;
    logic signed [bdq_pkg::DATA_W-1:0] out_value;
    logic [CNT_W-1:0]                  occupancy;
    logic                              last;

    modport source (output valid, output status, output out_value, output occupancy,
                    output last, input ready);
    modport sink   (input valid, input status, input out_value, input occupancy,
                    input last, output ready);

endinterface

// File: sv/bounded_deque_with_dump_unit.sv
// Top level of the bounded deque unit: ring pointers, command sequencing and result staging.
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH signed 32-bit values kept in a ring in one
// synchronous RAM. A push or pop command gives one result beat; a pop's value comes out
// of the RAM in the cycle after the command is taken. A dump of n elements gives n beats
// marked last on the final one. It occupies the sequencer until its last element is read,
// so new commands are held off meanwhile; the RAM's single read port delivers one element
// per cycle while the result side takes a beat every cycle. Pops and dumps on an empty
// queue and pushes on a full queue each give one beat with a status code; codes 6 and 7
// are taken and dropped without a result. Results pass through a pending slot and an
// output register, so one new command is taken while a finished result still waits. The
// store holds no defined contents after reset and needs no clearing pass: only entries
// that were pushed are ever read.
module bounded_deque_with_dump_unit #(
    parameter int DEPTH = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    bdq_in_if.sink   req,
    bdq_out_if.source rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(DEPTH);
    localparam logic [IDX_W:0]   DEPTH_WRAP = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(DEPTH - 1);

    // Sequencer states.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    // Ring index arithmetic: base plus an offset below DEPTH, wrapped once.
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_WRAP)
        begin
            sum = sum - DEPTH_WRAP;
        end
        return sum[IDX_W-1:0];
    endfunction

    logic                  state_reg, state_next;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      walk_reg, walk_next;
    logic                  rev_reg, rev_next;

    // Pending result slot, filled when a command is sequenced.
    logic                  pend_valid_reg, pend_valid_next;
    logic                  pend_ram_reg, pend_ram_next;
    logic [bdq_pkg::STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [CNT_W-1:0]      pend_occ_reg, pend_occ_next;
    logic                  pend_last_reg, pend_last_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [bdq_pkg::STATUS_W-1:0] out_status_reg;
    logic [bdq_pkg::DATA_W-1:0]   out_value_reg;
    logic [CNT_W-1:0]      out_occ_reg;
    logic                  out_last_reg;

    logic                  wr_en, rd_en;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    logic [bdq_pkg::DATA_W-1:0] rd_data;

    logic                  pend_move, pend_free, accept;
    logic                  full, empty;
    logic [CNT_W-1:0]      count_m1;
    logic [CNT_W-1:0]      walk_sel;
    logic                  rev_sel;
    logic [CNT_W-1:0]      dump_off;
    logic [IDX_W-1:0]      dump_addr;
    logic                  dump_last;

    bdq_ram #(
        .WIDTH (bdq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Handshake bookkeeping between the pending slot and the output register.
    assign pend_move = pend_valid_reg && (!out_valid_reg || rsp.ready);
    assign pend_free = !pend_valid_reg || pend_move;
    assign req.ready = (state_reg == S_IDLE) && pend_free;
    assign accept    = req.valid && req.ready;

    assign full     = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - CNT_W'(1);

    // Dump walk address: the first element is read in the accepting cycle.
    assign walk_sel  = (state_reg == S_IDLE) ? '0 : walk_reg;
    assign rev_sel   = (state_reg == S_IDLE) ? (req.cmd == bdq_pkg::CMD_DUMP_REV) : rev_reg;
    assign dump_off  = rev_sel ? (count_m1 - walk_sel) : walk_sel;
    assign dump_addr = wrap_add(front_reg, dump_off[IDX_W-1:0]);
    assign dump_last = (walk_sel == count_m1);

    // Command sequencing and RAM access.
    always_comb
    begin
        state_next       = state_reg;
        front_next       = front_reg;
        count_next       = count_reg;
        walk_next        = walk_reg;
        rev_next         = rev_reg;
        pend_valid_next  = pend_valid_reg && !pend_move;
        pend_ram_next    = pend_ram_reg;
        pend_status_next = pend_status_reg;
        pend_occ_next    = pend_occ_reg;
        pend_last_next   = pend_last_reg;
        wr_en            = 1'b0;
        wr_addr          = front_reg;
        rd_en            = 1'b0;
        rd_addr          = front_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.cmd)
                        bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_REAR:
                        begin
                            pend_valid_next = 1'b1;
                            pend_ram_next   = 1'b0;
                            pend_last_next  = 1'b1;
                            if (full)
                            begin
                                pend_status_next = bdq_pkg::ST_FULL;
                                pend_occ_next    = count_reg;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                if (req.cmd == bdq_pkg::CMD_PUSH_FRONT)
                                begin
                                    front_next = (front_reg == '0) ? LAST_IDX
                                                                   : front_reg - IDX_W'(1);
                                    wr_addr    = front_next;
                                end
                                else
                                begin
                                    wr_addr = wrap_add(front_reg, count_reg[IDX_W-1:0]);
                                end
                                count_next       = count_reg + CNT_W'(1);
                                pend_status_next = bdq_pkg::ST_OK;
                                pend_occ_next    = count_next;
                            end
                        end
                        bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_REAR:
                        begin
                            pend_valid_next = 1'b1;
                            pend_last_next  = 1'b1;
                            if (empty)
                            begin
                                pend_ram_next    = 1'b0;
                                pend_status_next = bdq_pkg::ST_EMPTY;
                                pend_occ_next    = '0;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                                if (req.cmd == bdq_pkg::CMD_POP_FRONT)
                                begin
                                    rd_addr    = front_reg;
                                    front_next = wrap_add(front_reg, IDX_W'(1));
                                end
                                else
                                begin
                                    rd_addr = wrap_add(front_reg, count_m1[IDX_W-1:0]);
                                end
                                count_next       = count_m1;
                                pend_ram_next    = 1'b1;
                                pend_status_next = bdq_pkg::ST_OK;
                                pend_occ_next    = count_m1;
                            end
                        end
                        bdq_pkg::CMD_DUMP_FWD, bdq_pkg::CMD_DUMP_REV:
                        begin
                            pend_valid_next = 1'b1;
                            pend_occ_next   = count_reg;
                            if (empty)
                            begin
                                pend_ram_next    = 1'b0;
                                pend_status_next = bdq_pkg::ST_EMPTY;
                                pend_last_next   = 1'b1;
                            end
                            else
                            begin
                                rd_en            = 1'b1;
                                rd_addr          = dump_addr;
                                pend_ram_next    = 1'b1;
                                pend_status_next = bdq_pkg::ST_OK;
                                pend_last_next   = dump_last;
                                rev_next         = rev_sel;
                                walk_next        = CNT_W'(1);
                                if (!dump_last)
                                begin
                                    state_next = S_DUMP;
                                end
                            end
                        end
                        default:
                        begin
                            // Unused codes are taken and dropped.
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (pend_free)
                begin
                    rd_en            = 1'b1;
                    rd_addr          = dump_addr;
                    pend_valid_next  = 1'b1;
                    pend_ram_next    = 1'b1;
                    pend_status_next = bdq_pkg::ST_OK;
                    pend_occ_next    = count_reg;
                    pend_last_next   = dump_last;
                    walk_next        = walk_reg + CNT_W'(1);
                    if (dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register loads from the pending slot whenever it is free or drained.
    assign out_valid_next = (!out_valid_reg || rsp.ready) ? pend_valid_reg : out_valid_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            front_reg      <= '0;
            count_reg      <= '0;
            walk_reg       <= '0;
            rev_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            front_reg      <= front_next;
            count_reg      <= count_next;
            walk_reg       <= walk_next;
            rev_reg        <= rev_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload of the pending slot and the output register.
    always_ff @(posedge clk)
    begin
        pend_ram_reg    <= pend_ram_next;
        pend_status_reg <= pend_status_next;
        pend_occ_reg    <= pend_occ_next;
        pend_last_reg   <= pend_last_next;
        if (pend_move)
        begin
            out_status_reg <= pend_status_reg;
            out_value_reg  <= pend_ram_reg ? rd_data : '0;
            out_occ_reg    <= pend_occ_reg;
            out_last_reg   <= pend_last_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.out_value = out_value_reg;
    assign rsp.occupancy = out_occ_reg;
    assign rsp.last      = out_last_reg;

`ifndef SYNTH
    // The element count never exceeds the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("element count above depth");

    // A RAM read is issued only when the pending slot can take its data.
    a_read_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> pend_free)
        else $error("RAM read would overwrite a pending result");

    // A dump walk leaves the ring pointers untouched.
    a_dump_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |=> ($stable(count_reg) && $stable(front_reg)))
        else $error("ring changed during dump");

    // A dropped push always reports a full ring.
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && (pend_status_reg == bdq_pkg::ST_FULL)) |->
        (pend_occ_reg == DEPTH_CNT))
        else $error("full status with a partly filled ring");

    // Only dump beats can be other than last, and they carry data.
    a_nonlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (out_status_reg == bdq_pkg::ST_OK))
        else $error("non-final beat with an error status");
`endif

endmodule

// File: sv/bdq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data register holds its value until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: verif/tb_bounded_deque_with_dump_unit.sv
// Self-checking testbench for the bounded deque unit with a scoreboard and randomized traffic.
`timescale 1ns / 1ps

module tb_bounded_deque_with_dump_unit;

    localparam int DEPTH           = 16;
    localparam int CNT_W           = 5;
    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int MAX_GAP         = 16;
    localparam int HOLD_CYCLES     = 240;
    localparam int RANDOM_COMMANDS = 280;
    localparam int IDLE_LIMIT      = 2000;
    localparam int SETTLE_CYCLES   = 40;

    // Codes that the block takes and drops without a result.
    localparam logic [bdq_pkg::CMD_W-1:0] CMD_UNUSED_A = 3'd6;
    localparam logic [bdq_pkg::CMD_W-1:0] CMD_UNUSED_B = 3'd7;

    // Command mixes for the random traffic.
    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

    typedef struct packed {
        logic [bdq_pkg::STATUS_W-1:0]      status;
        logic signed [bdq_pkg::DATA_W-1:0] value;
        logic [CNT_W-1:0]                  occupancy;
        logic                              last;
    } result_beat_t;

    // Deque predictor and the store of expected result beats.
    class deque_scoreboard;
        logic signed [bdq_pkg::DATA_W-1:0] ring [DEPTH];
        int                                head;
        int                                held;
        int                                errors;
        result_beat_t                      expected_beats[$];

        function new();
            head   = 0;
            held   = 0;
            errors = 0;
        endfunction

        function int slot(int offset);
            return (head + offset) % DEPTH;
        endfunction

        function void add_beat(logic [bdq_pkg::STATUS_W-1:0] status,
                               logic signed [bdq_pkg::DATA_W-1:0] value, logic last);
            result_beat_t beat;
            beat.status    = status;
            beat.value     = value;
            beat.occupancy = CNT_W'(held);
            beat.last      = last;
            expected_beats.push_back(beat);
        endfunction

        // Update the deque for one accepted command and queue the beats it causes.
        function void note_command(logic [bdq_pkg::CMD_W-1:0] code,
                                   logic signed [bdq_pkg::DATA_W-1:0] value);
            int                                i;
            int                                offset;
            logic signed [bdq_pkg::DATA_W-1:0] popped;
            case (code)
                bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_REAR:
                begin
                    if (held >= DEPTH)
                    begin
                        add_beat(bdq_pkg::ST_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        if (code == bdq_pkg::CMD_PUSH_FRONT)
                        begin
                            head = (head + DEPTH - 1) % DEPTH;
                            ring[head] = value;
                        end
                        else
                        begin
                            ring[slot(held)] = value;
                        end
                        held++;
                        add_beat(bdq_pkg::ST_OK, '0, 1'b1);
                    end
                end
                bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_REAR:
                begin
                    if (held == 0)
                    begin
                        add_beat(bdq_pkg::ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        if (code == bdq_pkg::CMD_POP_FRONT)
                        begin
                            popped = ring[head];
                            head = (head + 1) % DEPTH;
                        end
                        else
                        begin
                            popped = ring[slot(held - 1)];
                        end
                        held--;
                        add_beat(bdq_pkg::ST_OK, popped, 1'b1);
                    end
                end
                bdq_pkg::CMD_DUMP_FWD, bdq_pkg::CMD_DUMP_REV:
                begin
                    if (held == 0)
                    begin
                        add_beat(bdq_pkg::ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        for (i = 0; i < held; i++)
                        begin
                            offset = (code == bdq_pkg::CMD_DUMP_FWD) ? i : held - 1 - i;
                            add_beat(bdq_pkg::ST_OK, ring[slot(offset)], i == held - 1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        // Compare one accepted result beat with the oldest expectation.
        function void check_result(logic [bdq_pkg::STATUS_W-1:0] status,
                                   logic signed [bdq_pkg::DATA_W-1:0] value,
                                   logic [CNT_W-1:0] occupancy, logic last);
            result_beat_t want;
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result beat: status %0d value %0d", status, value);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            if (status !== want.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (value !== want.value)
            begin
                $error("out_value mismatch: expected %0d, actual %0d", want.value, value);
                errors++;
            end
            if (occupancy !== want.occupancy)
            begin
                $error("occupancy mismatch: expected %0d, actual %0d", want.occupancy, occupancy);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last mismatch: expected %0d, actual %0d", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bdq_in_if                   req_if();
    bdq_out_if #(.CNT_W(CNT_W)) rsp_if();

    bounded_deque_with_dump_unit #(.DEPTH(DEPTH)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    deque_scoreboard sb;
    bit              no_idle;
    bit              hold_request;
    int              sent_commands;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Values biased toward the extremes, with plenty of fully random words.
    function automatic logic signed [bdq_pkg::DATA_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom_range(0, 15);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Pick a command whose mix steers the occupancy up, down or around the middle.
    function automatic logic [bdq_pkg::CMD_W-1:0] random_command(mix_t mix);
        int roll;
        int push_pct;
        int pop_pct;
        roll     = $urandom_range(0, 99);
        push_pct = (mix == MIX_GROW) ? 60 : (mix == MIX_SHRINK) ? 20 : 40;
        pop_pct  = (mix == MIX_GROW) ? 25 : (mix == MIX_SHRINK) ? 65 : 45;
        if (roll < push_pct)
            return $urandom_range(0, 1) ? bdq_pkg::CMD_PUSH_REAR : bdq_pkg::CMD_PUSH_FRONT;
        else if (roll < push_pct + pop_pct)
            return $urandom_range(0, 1) ? bdq_pkg::CMD_POP_REAR : bdq_pkg::CMD_POP_FRONT;
        else if (roll < push_pct + pop_pct + 10)
            return $urandom_range(0, 1) ? bdq_pkg::CMD_DUMP_REV : bdq_pkg::CMD_DUMP_FWD;
        else
            return $urandom_range(0, 1) ? CMD_UNUSED_B : CMD_UNUSED_A;
    endfunction

    // Offer one command beat, after a random gap unless no_idle is set, and wait until it is taken.
    task automatic send_command(input logic [bdq_pkg::CMD_W-1:0] code,
                                input logic signed [bdq_pkg::DATA_W-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.cmd        <= code;
        req_if.push_value <= value;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        sb.note_command(code, value);
        if (code != CMD_UNUSED_A && code != CMD_UNUSED_B)
            sent_commands++;
    endtask

    // Stop offering commands until every expected beat has come back.
    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Result side: random stalls, an occasional long hold-off, and a check of every beat.
    initial
    begin : result_sink
        int stall;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_if.valid !== 1'b1);
            sb.check_result(rsp_if.status, rsp_if.out_value, rsp_if.occupancy, rsp_if.last);
        end
    end

    // Watchdog: too many cycles without any beat on either channel ends the run.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("bounded_deque_with_dump_unit regression: fail");
        $finish;
    end

    // Main sequence: reset, directed commands, a back-pressure phase, then random traffic.
    initial
    begin : stimulus
        int   i;
        int   target;
        int   iteration;
        bit   paused;
        mix_t mix;

        sb                = new();
        no_idle           = 1'b0;
        hold_request      = 1'b0;
        sent_commands     = 0;
        rst_n             <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.cmd        <= bdq_pkg::CMD_PUSH_FRONT;
        req_if.push_value <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pops and dumps of both kinds on an empty queue.
        send_command(bdq_pkg::CMD_POP_FRONT, 32'sh0);
        send_command(bdq_pkg::CMD_POP_REAR, 32'shFFFF_FFFF);
        send_command(bdq_pkg::CMD_DUMP_FWD, 32'sh0);
        send_command(bdq_pkg::CMD_DUMP_REV, 32'sh0);

        // Extreme values at both ends, then the unused codes, which must stay silent.
        send_command(bdq_pkg::CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_command(bdq_pkg::CMD_PUSH_REAR, 32'sh8000_0000);
        send_command(bdq_pkg::CMD_PUSH_FRONT, 32'shFFFF_FFFF);
        send_command(bdq_pkg::CMD_PUSH_REAR, 32'sh0);
        send_command(CMD_UNUSED_A, 32'sh5A5A_5A5A);
        send_command(CMD_UNUSED_B, 32'shA5A5_A5A5);

        // Dumps both ways, then pop everything and one more.
        send_command(bdq_pkg::CMD_DUMP_FWD, 32'sh0);
        send_command(bdq_pkg::CMD_DUMP_REV, 32'sh0);
        send_command(bdq_pkg::CMD_POP_FRONT, 32'sh0);
        send_command(bdq_pkg::CMD_POP_REAR, 32'sh0);
        send_command(bdq_pkg::CMD_POP_FRONT, 32'sh0);
        send_command(bdq_pkg::CMD_POP_REAR, 32'sh0);
        send_command(bdq_pkg::CMD_POP_REAR, 32'sh0);
        wait_for_results();

        // The result side holds off while pushes keep coming, so the input stalls; the pushes
        // then fill the queue, and those past full are dropped.
        hold_request = 1'b1;
        no_idle      = 1'b1;
        for (i = 0; i < DEPTH + 4; i++)
            send_command((i % 2) ? bdq_pkg::CMD_PUSH_REAR : bdq_pkg::CMD_PUSH_FRONT,
                         random_value());
        send_command(bdq_pkg::CMD_DUMP_FWD, 32'sh0);
        send_command(bdq_pkg::CMD_DUMP_REV, 32'sh0);
        no_idle = 1'b0;
        wait_for_results();

        // Random traffic in stretches of different mixes, some with no idling at all.
        target    = sent_commands + RANDOM_COMMANDS;
        iteration = 0;
        paused    = 1'b0;
        mix       = MIX_GROW;
        while (sent_commands < target)
        begin
            if (iteration % 32 == 0)
            begin
                mix     = mix_t'($urandom_range(0, 2));
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (!paused && sent_commands >= target - RANDOM_COMMANDS / 2)
            begin
                paused = 1'b1;
                wait_for_results();
            end
            send_command(random_command(mix), random_value());
            iteration++;
        end
        req_if.valid <= 1'b0;

        // Let the last beats drain, then give the verdict.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("bounded_deque_with_dump_unit regression: pass");
        else
            $display("bounded_deque_with_dump_unit regression: fail");
        $finish;
    end

endmodule

// File: files.f
sv/bdq_pkg.sv
sv/bdq_in_if.sv
sv/bdq_out_if.sv
sv/bdq_ram.sv
sv/bounded_deque_with_dump_unit.sv
verif/tb_bounded_deque_with_dump_unit.sv
